// ===== design/mmgr_pkg.sv =====
package mmgr_pkg;

  localparam int DEF_MAX_INPUTS  = 32;
  localparam int DEF_MAX_OUTPUTS = 16;
  localparam int MAX_BLOCK       = 4096;
  localparam int SAMPLE_BITS     = 24;

  localparam int GAIN_BITS = 18;
  localparam int GAIN_FRAC = 16;
  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1 << GAIN_FRAC);

  localparam int CH_W     = 5;
  localparam int TGT_W    = 4;
  localparam int OUT_CH_W = 4;

  localparam int NIN_CFG_W  = 6;
  localparam int NOUT_CFG_W = 5;
  localparam int BLK_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DW     = 13;

  localparam int DIV_NW    = GAIN_BITS + BLK_W;
  localparam int DIV_STEPS = GAIN_BITS;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  localparam int MUL_AW = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS + 1;
  localparam int MUL_BW = GAIN_BITS + 1;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam int ACC_W = 64;
  localparam logic signed [ACC_W-1:0] ACC_SMAX =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ACC_SMIN = -ACC_SMAX - ACC_W'(1);

  typedef logic [GAIN_BITS-1:0] gain_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_GAIN   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_INPUTS  = 3'd0,
    REG_NUM_OUTPUTS = 3'd1,
    REG_ONE_TO_ONE  = 3'd2,
    REG_BLOCK_LEN   = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t                     opcode;
    logic [CH_W-1:0]         in_channel;
    logic [TGT_W-1:0]        target_output;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [GAIN_BITS-1:0]    gain_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_CH_W-1:0]     out_channel;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                    frame_end;
  } out_item_t;

  typedef struct packed {
    logic start_we;
    logic target_we;
    logic pending_we;
  } gs_wen_t;

  typedef struct packed {
    gain_t start;
    gain_t target;
    gain_t pending;
  } gs_rd_t;

endpackage

// ===== design/mmgr_div.sv =====
module mmgr_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mmgr_pkg::DIV_NW-1:0]    num,
  input  logic [mmgr_pkg::BLK_W-1:0]     den,
  output logic                           done,
  output logic [mmgr_pkg::GAIN_BITS-1:0] quo
);

  logic [mmgr_pkg::DIV_NW-1:0] rem;
  logic [mmgr_pkg::DIV_NW-1:0] dsh;
  logic [mmgr_pkg::DIV_CW-1:0] cnt;
  logic                        busy;
  logic                        ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= mmgr_pkg::DIV_NW'(den) << (mmgr_pkg::DIV_STEPS - 1);
        quo  <= '0;
        cnt  <= mmgr_pkg::DIV_CW'(mmgr_pkg::DIV_STEPS);
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quo <= {quo[mmgr_pkg::GAIN_BITS-2:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt - mmgr_pkg::DIV_CW'(1);
        if (cnt == mmgr_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/mmgr_gstore.sv =====
module mmgr_gstore #(
  parameter int PAIRS = mmgr_pkg::DEF_MAX_INPUTS * mmgr_pkg::DEF_MAX_OUTPUTS,
  parameter int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1
) (
  input  logic              clk,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  mmgr_pkg::gs_wen_t wen,
  input  mmgr_pkg::gain_t   wd_start,
  input  mmgr_pkg::gain_t   wd_target,
  input  mmgr_pkg::gain_t   wd_pending,
  output mmgr_pkg::gs_rd_t  rd
);

  mmgr_pkg::gain_t mem_start   [PAIRS];
  mmgr_pkg::gain_t mem_target  [PAIRS];
  mmgr_pkg::gain_t mem_pending [PAIRS];

  always_ff @(posedge clk) begin
    if (wen.start_we) begin
      mem_start[wr_addr] <= wd_start;
    end
    if (wen.target_we) begin
      mem_target[wr_addr] <= wd_target;
    end
    if (wen.pending_we) begin
      mem_pending[wr_addr] <= wd_pending;
    end
    rd.start   <= mem_start[rd_addr];
    rd.target  <= mem_target[rd_addr];
    rd.pending <= mem_pending[rd_addr];
  end

endmodule

// ===== design/matrix_mixer_gain_ramp.sv =====
// Matrix mixer with per-pair linear gain ramps.
// The input channel carries one beat per sample or per pending-gain write;
// the opcode field tells them apart. A gain write is stored from the idle
// state. A sample is multiplied by a ramped gain for each active output
// (only the output of its own index in one-to-one mode), one output at a
// time through a shared multiplier and an 18-step iterative divider. The
// first sample of a ramp block first copies the gain memories for every
// pair (target to start, pending to target) before it is mixed.
// When the last input channel of a frame arrives, one output beat per
// active output leaves through an output register, ascending, with
// frame_end set on the last one. If the receiver stalls, the mixer holds
// its next result and waits; it takes a new input beat once the whole
// frame has been handed to the output register.
// After reset the block runs a clearing pass over all PAIRS pairs that loads
// unity gain on the diagonal and zero elsewhere; no input beat is taken
// during that pass. The configuration channel is always ready and should
// only be written while the mixer is idle.
module matrix_mixer_gain_ramp #(
  parameter int MAX_INPUTS  = mmgr_pkg::DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = mmgr_pkg::DEF_MAX_OUTPUTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mmgr_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mmgr_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mmgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmgr_pkg::CFG_DW-1:0]     cfg_data
);

  localparam int PAIRS = MAX_INPUTS * MAX_OUTPUTS;
  localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int CW    = AW + 1;
  localparam int OW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int IW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  typedef enum logic [10:0] {
    S_INIT = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_COPY = 11'b00000000100,
    S_RD   = 11'b00000001000,
    S_MUL  = 11'b00000010000,
    S_DST  = 11'b00000100000,
    S_DIV  = 11'b00001000000,
    S_GAIN = 11'b00010000000,
    S_ACC  = 11'b00100000000,
    S_END  = 11'b01000000000,
    S_EMIT = 11'b10000000000
  } state_t;

  state_t state;

  logic [mmgr_pkg::NIN_CFG_W-1:0]  num_inputs;
  logic [mmgr_pkg::NOUT_CFG_W-1:0] num_outputs;
  logic                            one_to_one;
  logic [mmgr_pkg::BLK_W-1:0]      block_length;

  logic [CW-1:0] cnt;
  logic [IW-1:0] row;
  logic [OW-1:0] col;
  logic          cp_wr;
  logic [AW-1:0] cp_addr;

  logic                              frame_open;
  logic [mmgr_pkg::BLK_W-1:0]        pos;
  logic [mmgr_pkg::CH_W-1:0]         ch_q;
  logic signed [mmgr_pkg::SAMPLE_BITS-1:0] sample_q;
  logic [OW-1:0]                     o_q;
  logic                              skip_q;
  mmgr_pkg::gain_t                   s_q;
  logic                              neg_q;
  mmgr_pkg::gain_t                   gain_q;
  logic signed [mmgr_pkg::MUL_PW-1:0] prod_q;
  logic signed [mmgr_pkg::ACC_W-1:0] acc [MAX_OUTPUTS];

  logic [6:0]                 nin;
  logic [6:0]                 nout;
  logic [6:0]                 nout_m1;
  logic [mmgr_pkg::BLK_W-1:0] len;
  logic [mmgr_pkg::BLK_W-1:0] n;
  logic [mmgr_pkg::BLK_W:0]   pos_inc;

  logic smp_ok;
  logic gw_ok;
  logic emit_go;

  logic [AW-1:0]     gs_rd_addr;
  logic [AW-1:0]     gs_wr_addr;
  mmgr_pkg::gs_wen_t gs_wen;
  mmgr_pkg::gain_t   wd_start;
  mmgr_pkg::gain_t   wd_target;
  mmgr_pkg::gain_t   wd_pending;
  mmgr_pkg::gs_rd_t  gs_rd;
  mmgr_pkg::gain_t   init_gain;
  logic [AW-1:0]     pair_addr;
  logic [AW-1:0]     gw_addr;

  logic signed [mmgr_pkg::GAIN_BITS:0] diff;
  logic [mmgr_pkg::GAIN_BITS-1:0]      mag;
  logic signed [mmgr_pkg::MUL_AW-1:0]  mul_a;
  logic signed [mmgr_pkg::MUL_BW-1:0]  mul_b;
  logic signed [mmgr_pkg::MUL_PW-1:0]  prod;

  logic                           dv_start;
  logic                           dv_done;
  logic [mmgr_pkg::GAIN_BITS-1:0] dv_quo;
  mmgr_pkg::gain_t                gain_calc;

  logic signed [mmgr_pkg::ACC_W-1:0] acc_rd;
  logic signed [mmgr_pkg::ACC_W-1:0] acc_sh;
  logic signed [mmgr_pkg::ACC_W-1:0] acc_sat;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign emit_go   = (state == S_EMIT) && (!out_valid || out_ready);

  assign nin = (num_inputs == '0) ? 7'd1 :
               ({1'b0, num_inputs} > 7'(MAX_INPUTS)) ? 7'(MAX_INPUTS) : {1'b0, num_inputs};
  assign nout = (num_outputs == '0) ? 7'd1 :
                ({2'b0, num_outputs} > 7'(MAX_OUTPUTS)) ? 7'(MAX_OUTPUTS) :
                {2'b0, num_outputs};
  assign nout_m1 = nout - 7'd1;
  assign len = (block_length == '0) ? mmgr_pkg::BLK_W'(1) :
               (block_length > mmgr_pkg::BLK_W'(mmgr_pkg::MAX_BLOCK)) ?
               mmgr_pkg::BLK_W'(mmgr_pkg::MAX_BLOCK) : block_length;
  assign n = (pos < len) ? pos : len;
  assign pos_inc = {1'b0, pos} + (mmgr_pkg::BLK_W + 1)'(1);

  assign smp_ok = (in_data.opcode == mmgr_pkg::OP_SAMPLE) && ({2'b0, in_data.in_channel} < nin);
  assign gw_ok  = (in_data.opcode == mmgr_pkg::OP_GAIN) &&
                  (int'(in_data.in_channel) < MAX_INPUTS) &&
                  (int'(in_data.target_output) < MAX_OUTPUTS);

  assign pair_addr = AW'(int'(ch_q) * MAX_OUTPUTS + int'(o_q));
  assign gw_addr   = AW'(int'(in_data.in_channel) * MAX_OUTPUTS + int'(in_data.target_output));
  assign init_gain = (int'(row) == int'(col)) ? mmgr_pkg::GAIN_UNITY : '0;

  always_comb begin
    gs_rd_addr = pair_addr;
    gs_wr_addr = cp_addr;
    gs_wen     = '0;
    wd_start   = gs_rd.target;
    wd_target  = gs_rd.pending;
    wd_pending = in_data.gain_value;
    case (state)
      S_INIT: begin
        gs_wr_addr = cnt[AW-1:0];
        gs_wen     = '{start_we: 1'b1, target_we: 1'b1, pending_we: 1'b1};
        wd_start   = init_gain;
        wd_target  = init_gain;
        wd_pending = init_gain;
      end
      S_COPY: begin
        gs_rd_addr = cnt[AW-1:0];
        gs_wen     = '{start_we: cp_wr, target_we: cp_wr, pending_we: 1'b0};
      end
      S_IDLE: begin
        gs_wr_addr = gw_addr;
        gs_wen     = '{start_we: 1'b0, target_we: 1'b0, pending_we: in_valid && gw_ok};
      end
      default: begin
      end
    endcase
  end

  mmgr_gstore #(
    .PAIRS (PAIRS),
    .AW    (AW)
  ) u_gstore (
    .clk        (clk),
    .rd_addr    (gs_rd_addr),
    .wr_addr    (gs_wr_addr),
    .wen        (gs_wen),
    .wd_start   (wd_start),
    .wd_target  (wd_target),
    .wd_pending (wd_pending),
    .rd         (gs_rd)
  );

  assign diff = $signed({1'b0, gs_rd.target}) - $signed({1'b0, gs_rd.start});
  assign mag  = diff[mmgr_pkg::GAIN_BITS] ? mmgr_pkg::GAIN_BITS'(-diff) :
                diff[mmgr_pkg::GAIN_BITS-1:0];

  always_comb begin
    if (state == S_MUL) begin
      mul_a = mmgr_pkg::MUL_AW'(mag);
      mul_b = mmgr_pkg::MUL_BW'(n);
    end else begin
      mul_a = mmgr_pkg::MUL_AW'(sample_q);
      mul_b = mmgr_pkg::MUL_BW'(gain_q);
    end
  end

  assign prod = mul_a * mul_b;

  assign dv_start = (state == S_DST);

  mmgr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (prod_q[mmgr_pkg::DIV_NW-1:0]),
    .den   (len),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  assign gain_calc = neg_q ? (s_q - dv_quo) : (s_q + dv_quo);

  assign acc_rd  = acc[o_q];
  assign acc_sh  = acc_rd >>> mmgr_pkg::GAIN_FRAC;
  assign acc_sat = (acc_sh > mmgr_pkg::ACC_SMAX) ? mmgr_pkg::ACC_SMAX :
                   (acc_sh < mmgr_pkg::ACC_SMIN) ? mmgr_pkg::ACC_SMIN : acc_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      cnt          <= '0;
      row          <= '0;
      col          <= '0;
      cp_wr        <= 1'b0;
      num_inputs   <= mmgr_pkg::NIN_CFG_W'(2);
      num_outputs  <= mmgr_pkg::NOUT_CFG_W'(2);
      one_to_one   <= 1'b0;
      block_length <= mmgr_pkg::BLK_W'(512);
      frame_open   <= 1'b0;
      pos          <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < MAX_OUTPUTS; i++) begin
        acc[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (mmgr_pkg::cfg_reg_t'(cfg_index))
          mmgr_pkg::REG_NUM_INPUTS:  num_inputs   <= cfg_data[mmgr_pkg::NIN_CFG_W-1:0];
          mmgr_pkg::REG_NUM_OUTPUTS: num_outputs  <= cfg_data[mmgr_pkg::NOUT_CFG_W-1:0];
          mmgr_pkg::REG_ONE_TO_ONE:  one_to_one   <= cfg_data[0];
          mmgr_pkg::REG_BLOCK_LEN:   block_length <= cfg_data[mmgr_pkg::BLK_W-1:0];
          default: begin
          end
        endcase
      end

      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_INIT: begin
          cnt <= cnt + CW'(1);
          if (int'(col) == MAX_OUTPUTS - 1) begin
            col <= '0;
            row <= row + IW'(1);
          end else begin
            col <= col + OW'(1);
          end
          if (int'(cnt) == PAIRS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && smp_ok) begin
            ch_q       <= in_data.in_channel;
            sample_q   <= in_data.in_sample;
            frame_open <= 1'b1;
            o_q        <= one_to_one ? OW'(in_data.in_channel) : '0;
            skip_q     <= one_to_one && (int'(in_data.in_channel) >= MAX_OUTPUTS);
            if (!frame_open && pos == '0) begin
              cnt   <= '0;
              cp_wr <= 1'b0;
              state <= S_COPY;
            end else if (one_to_one && (int'(in_data.in_channel) >= MAX_OUTPUTS)) begin
              state <= S_END;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_COPY: begin
          cp_wr   <= (int'(cnt) < PAIRS);
          cp_addr <= cnt[AW-1:0];
          if (int'(cnt) == PAIRS) begin
            state <= skip_q ? S_END : S_RD;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          s_q    <= gs_rd.start;
          neg_q  <= diff[mmgr_pkg::GAIN_BITS];
          prod_q <= prod;
          state  <= S_DST;
        end
        S_DST: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (dv_done) begin
            gain_q <= gain_calc;
            state  <= S_GAIN;
          end
        end
        S_GAIN: begin
          prod_q <= prod;
          state  <= S_ACC;
        end
        S_ACC: begin
          acc[o_q] <= acc_rd + mmgr_pkg::ACC_W'(prod_q);
          if (one_to_one || ({1'b0, o_q} == OW'(nout_m1) + (OW + 1)'(0))) begin
            state <= S_END;
          end else begin
            o_q   <= o_q + OW'(1);
            state <= S_RD;
          end
        end
        S_END: begin
          if ({2'b0, ch_q} == nin - 7'd1) begin
            o_q   <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_data.out_channel <= mmgr_pkg::OUT_CH_W'(o_q);
            out_data.out_sample  <= acc_sat[mmgr_pkg::SAMPLE_BITS-1:0];
            out_data.frame_end   <= (int'(o_q) == int'(nout_m1));
            if (int'(o_q) == int'(nout_m1)) begin
              for (int i = 0; i < MAX_OUTPUTS; i++) begin
                acc[i] <= '0;
              end
              frame_open <= 1'b0;
              pos        <= (pos_inc >= {1'b0, len}) ? '0 : pos_inc[mmgr_pkg::BLK_W-1:0];
              state      <= S_IDLE;
            end else begin
              o_q <= o_q + OW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> (state == S_DIV))
    else $error("divider finished outside of the divide state");

  a_emit_frame_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> frame_open)
    else $error("frame emitted without an open frame");

  a_sample_starts_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && smp_ok) |=> (state != S_IDLE))
    else $error("accepted sample did not start processing");

  a_copy_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    cp_wr |-> $past(state == S_COPY))
    else $error("gain copy write without a preceding copy read");

endmodule
